FILE: design/spps_pkg.sv
package spps_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int TABLE_AW = $clog2(TABLE_DEPTH);
	localparam int PARAM_COUNT = 7;

	localparam logic [4:0] PHASES_PER_PHONE = 5'd16;
	localparam logic [4:0] CLOSURE_MAX = 5'd28;
	localparam logic [5:0] UPDATE_WRAP = 6'h30;
	localparam logic [5:0] UPDATE_SLOW = 6'h28;
	localparam logic [7:0] PITCH_BASE = 8'he0;
	localparam logic [7:0] PITCH_MASK = 8'hf9;
	localparam logic [7:0] PITCH_COMMIT = 8'h08;
	localparam logic [8:0] PITCH_STEP = 9'd2;
	localparam logic [14:0] NOISE_FULL = 15'h7fff;
	localparam logic [5:0] PAUSE_CODE_A = 6'h03;
	localparam logic [5:0] PAUSE_CODE_B = 6'h3e;
	localparam logic [5:0] CODE_MASK = 6'h3f;

	localparam logic [2:0] K_FA = 3'd0;
	localparam logic [2:0] K_FC = 3'd1;
	localparam logic [2:0] K_VA = 3'd2;
	localparam logic [2:0] K_F1 = 3'd3;
	localparam logic [2:0] K_F2 = 3'd4;
	localparam logic [2:0] K_F2Q = 3'd5;
	localparam logic [2:0] K_F3 = 3'd6;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_COMMIT = 2'd1,
		OP_LOAD = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SMOOTH,
		ST_FINISH,
		ST_EMIT,
		ST_SCAN_RD,
		ST_SCAN_CMP
	} state_t;

endpackage

FILE: design/spps_table.sv
module spps_table
	import spps_pkg::*;
(
	input logic clk,
	input logic wr_en,
	input logic [TABLE_AW-1:0] wr_addr,
	input logic [63:0] wr_data,
	input logic [TABLE_AW-1:0] rd_addr,
	output logic [63:0] rd_data
);

	logic [63:0] mem [TABLE_DEPTH];
	logic [63:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/speech_phone_parameter_sequencer.sv
// A load transaction writes one 64-bit phone word into the table. A tick transaction runs
// through a tick step for the phase and update counters, a smoothing step in which one
// shared smoothing adder updates the seven parameters in turn, a finish step for closure,
// pitch, noise and filter commit, and an emit step that loads the output register once it
// is empty or being read. No new transaction is taken until the last one has finished.
// A commit transaction scans the phone table from entry 0 through its single read port,
// reading and then comparing one word at a time, until a match or the last entry. The
// input is accepted only when the sequencer is idle; a finished result may still wait in the
// output register while the next transaction is taken.
module speech_phone_parameter_sequencer
	import spps_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [79:0] s_tdata, // phone_code[5:0], table_index[11:6], table_word[75:12]
	input logic [1:0] s_tuser, // opcode[1:0]
	output logic m_tvalid,
	input logic m_tready,
	// pitch_phase[7:0], closure_level[12:8], noise_out[13], voice_amp[17:14],
	// noise_amp[21:18], noise_cutoff[25:22], formant_one[29:26], formant_two[34:30],
	// formant_two_q[38:35], formant_three[42:39], phone_done[43]
	output logic [47:0] m_tdata,
	input logic cfg_wen,
	input logic [1:0] cfg_wdata
);

	state_t state_q, state_d;
	opcode_t opcode;
	logic accept;
	logic [5:0] phone_code;
	logic [TABLE_AW-1:0] table_index;
	logic [63:0] table_word;

	logic [1:0] inflection_q;
	logic [5:0] code_q;
	logic [TABLE_AW-1:0] scan_q;
	logic [63:0] rd_word;

	logic [27:0] targets_q;
	logic [6:0] duration_q;
	logic [3:0] cld_q;
	logic [3:0] vd_q;
	logic closure_q;
	logic pause_q;
	logic [7:0] smoothed_q [PARAM_COUNT];
	logic [28:0] committed_q;
	logic [8:0] phase_ticks_q;
	logic [4:0] tick_count_q;
	logic [5:0] update_count_q;
	logic [7:0] pitch_count_q;
	logic [4:0] closure_count_q;
	logic closure_active_q;
	logic [14:0] noise_shift_q;
	logic noise_bit_q;
	logic tick_fast_q;
	logic tick_slow_q;
	logic [2:0] smooth_k_q;
	logic m_tvalid_q;
	logic [47:0] m_tdata_q;

	logic emit_go;
	logic match;
	logic sound_on;
	logic smooth_en;
	logic [3:0] target;
	logic [7:0] smooth_in;
	logic [7:0] smooth_out;
	logic [8:0] phase_next;
	logic [4:0] tick_next;
	logic [5:0] update_inc;
	logic [5:0] update_next;
	logic [8:0] pitch_end;
	logic [7:0] pitch_inc;
	logic [7:0] pitch_next;
	logic [14:0] noise_next;

	assign opcode = opcode_t'(s_tuser);
	assign phone_code = s_tdata[5:0];
	assign table_index = s_tdata[11:6];
	assign table_word = s_tdata[75:12];
	assign accept = s_tvalid && s_tready;
	assign emit_go = !m_tvalid_q || m_tready;

	spps_table u_table (
		.clk(clk),
		.wr_en(accept && opcode == OP_LOAD),
		.wr_addr(table_index),
		.wr_data(table_word),
		.rd_addr(scan_q),
		.rd_data(rd_word)
	);

	assign match = (rd_word[61:56] & CODE_MASK) == code_q;
	assign sound_on = committed_q[3:0] != 4'd0 || committed_q[11:8] != 4'd0;

	// Shared smoothing unit: r - r/8 + 2*target, modulo 256.
	assign target = targets_q[{smooth_k_q, 2'b00} +: 4];
	assign smooth_in = smoothed_q[smooth_k_q];
	assign smooth_out = smooth_in - {3'b000, smooth_in[7:3]} + {3'b000, target, 1'b0};

	always_comb begin
		unique case (smooth_k_q)
			K_FA: smooth_en = tick_fast_q && tick_count_q >= {1'b0, vd_q};
			K_VA: smooth_en = tick_fast_q && tick_count_q >= {1'b0, cld_q};
			default: smooth_en = tick_slow_q && (!pause_q || !sound_on);
		endcase
	end

	assign phase_next = phase_ticks_q + 9'd1;
	assign tick_next = tick_count_q + 5'd1;
	assign update_inc = update_count_q + 6'd1;
	assign update_next = (update_inc == UPDATE_WRAP) ? 6'd0 : update_inc;
	assign pitch_end = {1'b0, PITCH_BASE ^ {1'b0, inflection_q, 5'b00000}
		^ {3'b000, committed_q[15:12], 1'b0}} + PITCH_STEP;
	assign pitch_inc = pitch_count_q + 8'd1;
	assign pitch_next = ({1'b0, pitch_inc} == pitch_end) ? 8'd0 : pitch_inc;
	assign noise_next = {noise_shift_q[13:0], noise_bit_q && noise_shift_q != NOISE_FULL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (opcode)
						OP_TICK: state_d = ST_TICK;
						OP_COMMIT: state_d = ST_SCAN_RD;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK: state_d = ST_SMOOTH;
			ST_SMOOTH: begin
				if (smooth_k_q == K_F3) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (match || scan_q == TABLE_AW'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflection_q <= 2'd0;
			code_q <= 6'd0;
			scan_q <= '0;
			targets_q <= '0;
			duration_q <= '0;
			cld_q <= '0;
			vd_q <= '0;
			closure_q <= 1'b0;
			pause_q <= 1'b0;
			for (int i = 0; i < PARAM_COUNT; i++) begin
				smoothed_q[i] <= 8'd0;
			end
			committed_q <= '0;
			phase_ticks_q <= '0;
			tick_count_q <= '0;
			update_count_q <= '0;
			pitch_count_q <= '0;
			closure_count_q <= '0;
			closure_active_q <= 1'b1;
			noise_shift_q <= '0;
			noise_bit_q <= 1'b0;
			tick_fast_q <= 1'b0;
			tick_slow_q <= 1'b0;
			smooth_k_q <= K_FA;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (cfg_wen) begin
				inflection_q <= cfg_wdata;
			end
			if (state_q == ST_EMIT && emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && opcode == OP_COMMIT) begin
						code_q <= phone_code;
						scan_q <= '0;
						phase_ticks_q <= '0;
						tick_count_q <= '0;
					end
				end
				ST_TICK: begin
					if (tick_count_q != PHASES_PER_PHONE) begin
						if (phase_next == {duration_q, 2'b01}) begin
							phase_ticks_q <= '0;
							tick_count_q <= tick_next;
							if (tick_next == {1'b0, cld_q}) begin
								closure_active_q <= closure_q;
							end
						end else begin
							phase_ticks_q <= phase_next;
						end
					end
					update_count_q <= update_next;
					tick_fast_q <= update_next[3:0] == 4'd0;
					tick_slow_q <= update_next == UPDATE_SLOW;
					smooth_k_q <= K_FA;
				end
				ST_SMOOTH: begin
					if (smooth_en) begin
						smoothed_q[smooth_k_q] <= smooth_out;
					end
					if (smooth_k_q != K_F3) begin
						smooth_k_q <= smooth_k_q + 3'd1;
					end
				end
				ST_FINISH: begin
					if (!closure_active_q && sound_on) begin
						closure_count_q <= '0;
					end else if (closure_count_q != CLOSURE_MAX) begin
						closure_count_q <= closure_count_q + 5'd1;
					end
					pitch_count_q <= pitch_next;
					if ((pitch_next & PITCH_MASK) == PITCH_COMMIT) begin
						committed_q <= {smoothed_q[K_F3][7:4], smoothed_q[K_F2Q][7:4],
							smoothed_q[K_F2][7:3], smoothed_q[K_F1][7:4],
							smoothed_q[K_VA][7:4], smoothed_q[K_FC][7:4],
							smoothed_q[K_FA][7:4]};
					end
					noise_shift_q <= noise_next;
					noise_bit_q <= ~(noise_next[14] ^ noise_next[13]);
				end
				ST_EMIT: begin
					if (emit_go) begin
						m_tdata_q <= {4'd0, tick_count_q == PHASES_PER_PHONE,
							committed_q[28:25], committed_q[24:21], committed_q[20:16],
							committed_q[15:12], committed_q[7:4], committed_q[3:0],
							committed_q[11:8], noise_bit_q, closure_count_q, pitch_count_q};
					end
				end
				ST_SCAN_RD: begin
				end
				ST_SCAN_CMP: begin
					if (match) begin
						targets_q <= {
							rd_word[5], rd_word[12], rd_word[19], rd_word[26],
							rd_word[4], rd_word[11], rd_word[18], rd_word[25],
							rd_word[2], rd_word[9], rd_word[16], rd_word[23],
							rd_word[0], rd_word[7], rd_word[14], rd_word[21],
							rd_word[1], rd_word[8], rd_word[15], rd_word[22],
							rd_word[3], rd_word[10], rd_word[17], rd_word[24],
							rd_word[6], rd_word[13], rd_word[20], rd_word[27]};
						duration_q <= ~{rd_word[37], rd_word[38], rd_word[39], rd_word[40],
							rd_word[41], rd_word[42], rd_word[43]};
						cld_q <= {rd_word[34], rd_word[32], rd_word[30], rd_word[28]};
						vd_q <= {rd_word[35], rd_word[33], rd_word[31], rd_word[29]};
						closure_q <= rd_word[36];
						pause_q <= code_q == PAUSE_CODE_A || code_q == PAUSE_CODE_B;
						if ({rd_word[34], rd_word[32], rd_word[30], rd_word[28]} == 4'd0) begin
							closure_active_q <= rd_word[36];
						end
					end else begin
						scan_q <= scan_q + TABLE_AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	a_closure_bound: assert property (@(posedge clk) disable iff (!arst_n)
		closure_count_q <= CLOSURE_MAX)
		else $error("closure ramp went past its limit");

	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tick_count_q <= PHASES_PER_PHONE)
		else $error("phase tick count went past the phone length");

	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_COMMIT) |=> (tick_count_q == 5'd0 && phase_ticks_q == 9'd0))
		else $error("commit did not clear the phase counters");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && emit_go) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("tick result was not presented");

	a_update_bound: assert property (@(posedge clk) disable iff (!arst_n)
		update_count_q < UPDATE_WRAP)
		else $error("update counter left its range");

endmodule

FILE: tb/tb_speech_phone_parameter_sequencer.sv
module tb_speech_phone_parameter_sequencer;
	import spps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 840;
	localparam int CONFIG_SPACING = 190;
	localparam int SETTLE_CYCLES = 160;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 10;
	localparam logic [5:0] ABSENT_CODE = 6'h2a;

	typedef struct packed {
		logic [3:0] spare;
		logic phone_done;
		logic [3:0] formant_three;
		logic [3:0] formant_two_q;
		logic [4:0] formant_two;
		logic [3:0] formant_one;
		logic [3:0] noise_cutoff;
		logic [3:0] noise_amp;
		logic [3:0] voice_amp;
		logic noise_out;
		logic [4:0] closure_level;
		logic [7:0] pitch_phase;
	} param_frame_t;

	typedef struct packed {
		opcode_t op;
		logic [5:0] code;
		logic [5:0] index;
		logic [63:0] word;
		logic typed;
		param_frame_t frame;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [79:0] s_tdata; // phone_code[5:0], table_index[11:6], table_word[75:12]
	logic [1:0] s_tuser; // opcode[1:0]
	logic m_tvalid;
	logic m_tready;
	// pitch_phase[7:0], closure_level[12:8], noise_out[13], voice_amp[17:14],
	// noise_amp[21:18], noise_cutoff[25:22], formant_one[29:26], formant_two[34:30],
	// formant_two_q[38:35], formant_three[42:39], phone_done[43]
	logic [47:0] m_tdata;
	logic cfg_wen;
	logic [1:0] cfg_wdata;

	speech_phone_parameter_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	// Chip model state.
	logic [63:0] table_words [TABLE_DEPTH];
	logic [3:0] target_nib [PARAM_COUNT];
	logic [7:0] smoothed [PARAM_COUNT];
	logic [6:0] duration_q;
	logic [3:0] cld_q;
	logic [3:0] vd_q;
	logic closure_q;
	logic pause_q;
	logic [3:0] fa_c, fc_c, va_c, f1_c, f2q_c, f3_c;
	logic [4:0] f2_c;
	logic [8:0] phase_ticks;
	logic [4:0] tick_count;
	logic [5:0] update_count;
	logic [7:0] pitch_count;
	logic [4:0] closure_count;
	logic closure_active;
	logic [14:0] noise_shift;
	logic noise_bit;
	logic [1:0] inflection;

	param_frame_t param_queue [$];
	stim_row_t dir_rows [$];

	int errors = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int ticks_sent = 0;
	int commits_sent = 0;
	int commit_misses = 0;
	int loads_sent = 0;
	int ignored_sent = 0;
	int frames_checked = 0;
	int done_frames = 0;
	logic [3:0] infl_used = '0;

	function automatic logic [7:0] smooth_step(input logic [7:0] r, input logic [3:0] t);
		return r - (r >> 3) + {3'd0, t, 1'b0};
	endfunction

	function automatic logic select_phone(input logic [5:0] code);
		logic [63:0] w;
		logic found;
		found = 1'b0;
		w = '0;
		phase_ticks = '0;
		tick_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!found && table_words[i][61:56] == code) begin
				found = 1'b1;
				w = table_words[i];
			end
		end
		if (found) begin
			for (int b = 0; b < 7; b++)
				duration_q[6 - b] = ~w[37 + b];
			target_nib[K_F1] = {w[0], w[7], w[14], w[21]};
			target_nib[K_VA] = {w[1], w[8], w[15], w[22]};
			target_nib[K_F2] = {w[2], w[9], w[16], w[23]};
			target_nib[K_FC] = {w[3], w[10], w[17], w[24]};
			target_nib[K_F2Q] = {w[4], w[11], w[18], w[25]};
			target_nib[K_F3] = {w[5], w[12], w[19], w[26]};
			target_nib[K_FA] = {w[6], w[13], w[20], w[27]};
			cld_q = {w[34], w[32], w[30], w[28]};
			vd_q = {w[35], w[33], w[31], w[29]};
			closure_q = w[36];
			pause_q = (code == PAUSE_CODE_A) || (code == PAUSE_CODE_B);
			if (cld_q == 4'd0)
				closure_active = closure_q;
		end
		return found;
	endfunction

	function automatic param_frame_t advance_chip();
		param_frame_t f;
		logic tick_16;
		logic tick_48;
		logic sound_on;
		logic [8:0] pitch_end;
		if (tick_count != PHASES_PER_PHONE) begin
			phase_ticks = phase_ticks + 9'd1;
			if (phase_ticks == {duration_q, 2'b01}) begin
				phase_ticks = '0;
				tick_count = tick_count + 5'd1;
				if (tick_count == {1'b0, cld_q})
					closure_active = closure_q;
			end
		end

		update_count = update_count + 6'd1;
		if (update_count == UPDATE_WRAP)
			update_count = '0;
		tick_16 = update_count[3:0] == 4'd0;
		tick_48 = update_count == UPDATE_SLOW;
		sound_on = (fa_c != 4'd0) || (va_c != 4'd0);

		if (tick_48 && (!pause_q || !sound_on)) begin
			smoothed[K_FC] = smooth_step(smoothed[K_FC], target_nib[K_FC]);
			smoothed[K_F1] = smooth_step(smoothed[K_F1], target_nib[K_F1]);
			smoothed[K_F2] = smooth_step(smoothed[K_F2], target_nib[K_F2]);
			smoothed[K_F2Q] = smooth_step(smoothed[K_F2Q], target_nib[K_F2Q]);
			smoothed[K_F3] = smooth_step(smoothed[K_F3], target_nib[K_F3]);
		end
		if (tick_16) begin
			if (tick_count >= {1'b0, vd_q})
				smoothed[K_FA] = smooth_step(smoothed[K_FA], target_nib[K_FA]);
			if (tick_count >= {1'b0, cld_q})
				smoothed[K_VA] = smooth_step(smoothed[K_VA], target_nib[K_VA]);
		end

		if (!closure_active && sound_on)
			closure_count = '0;
		else if (closure_count != CLOSURE_MAX)
			closure_count = closure_count + 5'd1;

		// The end value can reach 256, in which case the counter just wraps.
		pitch_count = pitch_count + 8'd1;
		pitch_end = {1'b0, PITCH_BASE ^ {1'b0, inflection, 5'd0} ^ {3'd0, f1_c, 1'b0}}
			+ PITCH_STEP;
		if ({1'b0, pitch_count} == pitch_end)
			pitch_count = '0;

		if ((pitch_count & PITCH_MASK) == PITCH_COMMIT) begin
			fa_c = smoothed[K_FA][7:4];
			fc_c = smoothed[K_FC][7:4];
			va_c = smoothed[K_VA][7:4];
			f1_c = smoothed[K_F1][7:4];
			f2_c = smoothed[K_F2][7:3];
			f2q_c = smoothed[K_F2Q][7:4];
			f3_c = smoothed[K_F3][7:4];
		end

		noise_shift = {noise_shift[13:0], noise_bit && (noise_shift != NOISE_FULL)};
		noise_bit = ~(noise_shift[14] ^ noise_shift[13]);

		f = '0;
		f.pitch_phase = pitch_count;
		f.closure_level = closure_count;
		f.noise_out = noise_bit;
		f.voice_amp = va_c;
		f.noise_amp = fa_c;
		f.noise_cutoff = fc_c;
		f.formant_one = f1_c;
		f.formant_two = f2_c;
		f.formant_two_q = f2q_c;
		f.formant_three = f3_c;
		f.phone_done = tick_count == PHASES_PER_PHONE;
		return f;
	endfunction

	// Most table words get a short duration so that phones finish within a run of ticks.
	// The absent code is kept out of the table so that commits without a match happen.
	function automatic logic [63:0] phone_word(input logic [63:0] raw);
		logic [63:0] w;
		w = raw;
		if ($urandom_range(0, 9) < 6)
			w[41:37] = 5'h1f;
		if (w[61:56] == ABSENT_CODE)
			w[56] = ~w[56];
		return w;
	endfunction

	function automatic string frame_diff(input param_frame_t want, input param_frame_t got);
		string s;
		s = "";
		if (got.spare !== want.spare) s = {s, " spare"};
		if (got.phone_done !== want.phone_done) s = {s, " phone_done"};
		if (got.formant_three !== want.formant_three) s = {s, " formant_three"};
		if (got.formant_two_q !== want.formant_two_q) s = {s, " formant_two_q"};
		if (got.formant_two !== want.formant_two) s = {s, " formant_two"};
		if (got.formant_one !== want.formant_one) s = {s, " formant_one"};
		if (got.noise_cutoff !== want.noise_cutoff) s = {s, " noise_cutoff"};
		if (got.noise_amp !== want.noise_amp) s = {s, " noise_amp"};
		if (got.voice_amp !== want.voice_amp) s = {s, " voice_amp"};
		if (got.noise_out !== want.noise_out) s = {s, " noise_out"};
		if (got.closure_level !== want.closure_level) s = {s, " closure_level"};
		if (got.pitch_phase !== want.pitch_phase) s = {s, " pitch_phase"};
		return s;
	endfunction

	task automatic send_item(input opcode_t op, input logic [5:0] code, input logic [5:0] index,
			input logic [63:0] word, input logic typed, input param_frame_t typed_frame);
		param_frame_t f;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, word, index, code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (op)
			OP_TICK: begin
				f = advance_chip();
				param_queue.push_back(typed ? typed_frame : f);
				ticks_sent++;
			end
			OP_COMMIT: begin
				commits_sent++;
				if (!select_phone(code))
					commit_misses++;
			end
			OP_LOAD: begin
				table_words[index] = word;
				loads_sent++;
			end
			default: ignored_sent++;
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 14);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 12);
		end
	endtask

	// The sequencer may still be scanning the table after the last result, so settle first.
	task automatic write_inflection(input logic [1:0] value);
		s_tvalid <= 1'b0;
		while (param_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		inflection = value;
		infl_used[value] = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		int stall_left;
		int stall_mode;
		logic [12:0] ready_pattern;
		stall_left = 0;
		stall_mode = 0;
		ready_pattern = 13'b1011001110110;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 3) != 0;
				2: begin
					m_tready <= ready_pattern[0];
					ready_pattern = {ready_pattern[0], ready_pattern[12:1]};
				end
				default: m_tready <= $urandom_range(0, 1) == 1;
			endcase
		end
	end

	initial begin
		param_frame_t got;
		param_frame_t want;
		string diff;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = m_tdata;
				frames_checked++;
				if (param_queue.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("Result with none expected: %h", got);
				end else begin
					want = param_queue.pop_front();
					diff = frame_diff(want, got);
					if (want.phone_done)
						done_frames++;
					if (diff != "") begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("Mismatch in frame %0d:%s expected %h got %h",
								frames_checked, diff, want, got);
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", cycle_count);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		param_frame_t first_frame;
		logic [63:0] w;
		int random_items;
		int next_cfg_at;
		int phase_no;
		int pick;
		int entry;
		int run;
		int n;
		opcode_t op;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_TICK;
		cfg_wen = 1'b0;
		cfg_wdata = 2'd0;

		for (int i = 0; i < TABLE_DEPTH; i++)
			table_words[i] = '0;
		for (int k = 0; k < PARAM_COUNT; k++) begin
			target_nib[k] = '0;
			smoothed[k] = '0;
		end
		duration_q = '0;
		cld_q = '0;
		vd_q = '0;
		closure_q = 1'b0;
		pause_q = 1'b0;
		{fa_c, fc_c, va_c, f1_c, f2q_c, f3_c, f2_c} = '0;
		phase_ticks = '0;
		tick_count = '0;
		update_count = '0;
		pitch_count = '0;
		closure_count = '0;
		closure_active = 1'b1;
		noise_shift = '0;
		noise_bit = 1'b0;
		inflection = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_inflection(2'd3);

		// Every entry is written before any commit can scan the table. Entry 42 holds the
		// absent code's slot and repeats code zero, so the first match must win.
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			w = phone_word({$urandom, $urandom});
			w[61:56] = (6'(i) == ABSENT_CODE) ? 6'h00 : 6'(i);
			send_item(OP_LOAD, 6'($urandom), 6'(i), w, 1'b0, '0);
		end

		// Straight after reset the first tick changes only the pitch, closure and noise fields of the result.
		first_frame = '0;
		first_frame.pitch_phase = 8'd1;
		first_frame.closure_level = 5'd1;
		first_frame.noise_out = 1'b1;

		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b1, first_frame});
		dir_rows.push_back('{OP_TICK, 6'h3f, 6'h3f, '1, 1'b0, '0});
		dir_rows.push_back('{OP_COMMIT, 6'h3f, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_COMMIT, PAUSE_CODE_A, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_COMMIT, PAUSE_CODE_B, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_COMMIT, ABSENT_CODE, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_COMMIT, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_LOAD, 6'h00, 6'h3f, '1, 1'b0, '0});
		dir_rows.push_back('{OP_LOAD, 6'h3f, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_COMMIT, 6'h3f, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_COMMIT, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_NONE, 6'($urandom), 6'($urandom), {$urandom, $urandom}, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});
		dir_rows.push_back('{OP_TICK, 6'h00, 6'h00, 64'h0, 1'b0, '0});

		foreach (dir_rows[r])
			send_item(dir_rows[r].op, dir_rows[r].code, dir_rows[r].index, dir_rows[r].word,
				dir_rows[r].typed, dir_rows[r].frame);

		random_items = 0;
		next_cfg_at = CONFIG_SPACING;
		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= next_cfg_at) begin
				phase_no++;
				next_cfg_at += CONFIG_SPACING;
				case (phase_no)
					1: write_inflection(2'd0);
					2: write_inflection(2'd2);
					3: write_inflection(2'd1);
					default: write_inflection(2'($urandom_range(0, 3)));
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				entry = $urandom_range(0, TABLE_DEPTH - 1);
				send_item(OP_COMMIT, table_words[entry][61:56], 6'($urandom),
					{$urandom, $urandom}, 1'b0, '0);
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(10, 70);
				repeat (run)
					send_item(OP_TICK, 6'($urandom), 6'($urandom), {$urandom, $urandom}, 1'b0, '0);
				random_items += run + 1;
			end else if (pick < 78) begin
				send_item(OP_LOAD, 6'($urandom), 6'($urandom), phone_word({$urandom, $urandom}),
					1'b0, '0);
				random_items++;
			end else if (pick < 85) begin
				send_item(OP_COMMIT, ($urandom_range(0, 1) == 1) ? ABSENT_CODE : 6'($urandom),
					6'($urandom), {$urandom, $urandom}, 1'b0, '0);
				random_items++;
			end else if (pick < 90) begin
				send_item(OP_NONE, 6'($urandom), 6'($urandom), {$urandom, $urandom}, 1'b0, '0);
				random_items++;
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					op = opcode_t'($urandom_range(0, 2));
					send_item(op, 6'($urandom), 6'($urandom), phone_word({$urandom, $urandom}),
						1'b0, '0);
				end
				random_items += n;
			end
		end

		s_tvalid <= 1'b0;
		while (param_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (param_queue.size() != 0) begin
			errors += param_queue.size();
			$display("%0d expected results never arrived", param_queue.size());
		end

		$display("Sent %0d ticks, %0d commits (%0d with no matching phone), %0d table loads, %0d ignored",
			ticks_sent, commits_sent, commit_misses, loads_sent, ignored_sent);
		$display("Checked %0d parameter frames, %0d with the phone finished; inflection levels %b",
			frames_checked, done_frames, infl_used);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
design/spps_pkg.sv
design/spps_table.sv
design/speech_phone_parameter_sequencer.sv
tb/tb_speech_phone_parameter_sequencer.sv
